// ----- src/apsp_pkg.sv -----
// Shared types and constants for the all-pairs shortest path block.
`timescale 1ns / 1ps
`default_nettype none
package apsp_pkg;

	localparam int MAX_VERTICES = 8;

	typedef struct packed {
		logic        func;
		logic [2:0]  src_vertex;
		logic [2:0]  dst_vertex;
		logic [15:0] edge_weight;
	} apsp_in_t;

	typedef struct packed {
		logic [2:0]  from_vertex;
		logic [2:0]  to_vertex;
		logic        reachable;
		logic [18:0] path_length;
		logic [2:0]  next_hop;
		logic        last;
	} apsp_out_t;

	localparam logic       FUNC_EDGE  = 1'b0;
	localparam logic       FUNC_SOLVE = 1'b1;
	localparam logic [18:0] LEN_MAX   = 19'h7FFFF;
	localparam logic [3:0]  VC_RESET  = 4'd8;

endpackage
`default_nettype wire

// ----- src/apsp_front.sv -----
// Input queue: accepts items and hands them to the solver in order.
`timescale 1ns / 1ps
`default_nettype none
module apsp_front import apsp_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	output logic          in_ready,
	input  wire apsp_in_t in_item,
	output logic          q_valid,
	input  wire logic     q_ready,
	output apsp_in_t      q_item
);
	apsp_in_t   buf_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	logic       push, pop;

	assign in_ready = (cnt_q != 2'd2);
	assign q_valid  = (cnt_q != 2'd0);
	assign q_item   = buf_q[rp_q];
	assign push     = in_valid && in_ready;
	assign pop      = q_valid && q_ready;

	always_ff @(posedge clk) begin
		if (push) buf_q[wp_q] <= in_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n) cnt_q != 2'd3)
		else $error("queue count out of range");
	a_no_over: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q == 2'd2 |-> !push) else $error("push into full queue");
	a_cnt_step: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |=> cnt_q == $past(cnt_q) + 2'd1) else $error("count step");
endmodule
`default_nettype wire

// ----- src/apsp_back.sv -----
// Solver: edge store, relaxation sequencer and result emitter.
`timescale 1ns / 1ps
`default_nettype none
module apsp_back import apsp_pkg::*; #(
	parameter int WEIGHT_BITS  = 16
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic [3:0] vcount,
	input  wire logic     q_valid,
	output logic          q_ready,
	input  wire apsp_in_t q_item,
	output logic          out_valid,
	input  wire logic     out_ready,
	output apsp_out_t     out_item,
	output logic          busy
);
	localparam int VB = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
	localparam int NC = MAX_VERTICES * MAX_VERTICES;
	localparam int CB = $clog2(NC);
	localparam int DB = WEIGHT_BITS + 4;
	localparam int DW = (DB > 19) ? DB : 19;

	typedef enum logic [3:0] {
		S_IDLE, S_EDGE_A, S_EDGE_B, S_INIT, S_RIK, S_RKJ, S_RIJ, S_UPD,
		S_ERD, S_EWAIT, S_EOUT
	} st_t;

	st_t st_q;
	logic [MAX_VERTICES-1:0] pres_q [MAX_VERTICES];
	logic [WEIGHT_BITS-1:0]  wmem [NC];
	logic [DW-1:0]           dmem [NC];
	logic                    vmem [NC];
	logic [VB-1:0]           hmem [NC];
	logic [VB-1:0] i_q, j_q, k_q, a_q, b_q, n1_q;
	logic [WEIGHT_BITS-1:0] w_q, wrd_q;
	logic [DW-1:0] dik_q, dkj_q, drd_q;
	logic vik_q, vkj_q, vrd_q;
	logic [VB-1:0] hik_q, hrd_q;
	logic last_q, pre_q;
	logic [CB-1:0] ra;
	logic [DW:0] sum;

	function automatic logic [CB-1:0] ix(input logic [VB-1:0] r, input logic [VB-1:0] c);
		logic [2*VB-1:0] t;
		t = {VB'(0), r} * (2*VB)'(MAX_VERTICES) + {VB'(0), c};
		return t[CB-1:0];
	endfunction

	logic [3:0] nclip;
	always_comb begin
		if (vcount == 4'd0) nclip = 4'd1;
		else if ({28'd0, vcount} > MAX_VERTICES) nclip = 4'(MAX_VERTICES);
		else nclip = vcount;
	end

	assign q_ready = (st_q == S_IDLE);
	assign busy    = (st_q != S_IDLE);
	assign sum     = {1'b0, dik_q} + {1'b0, dkj_q};

	always_comb begin
		case (st_q)
			S_RIK:   ra = ix(i_q, k_q);
			S_RKJ:   ra = ix(k_q, j_q);
			default: ra = ix(i_q, j_q);
		endcase
	end

	always_ff @(posedge clk) begin
		wrd_q <= wmem[ra];
		drd_q <= dmem[ra];
		vrd_q <= vmem[ra];
		hrd_q <= hmem[ra];
		pre_q <= pres_q[i_q][j_q];
		if (st_q == S_EDGE_A && !pres_q[a_q][b_q]) wmem[ix(a_q, b_q)] <= w_q;
		if (st_q == S_EDGE_B && !pres_q[b_q][a_q]) wmem[ix(b_q, a_q)] <= w_q;
		if (st_q == S_INIT) begin
			dmem[ix(i_q, j_q)] <= (i_q == j_q || !pre_q) ? DW'(0) : DW'(wrd_q);
			vmem[ix(i_q, j_q)] <= (i_q == j_q) || pre_q;
			hmem[ix(i_q, j_q)] <= j_q;
		end
		// i,j read lands in this state; relax only on a strictly smaller sum
		if (st_q == S_UPD && vik_q && vkj_q && (!vrd_q || drd_q > sum[DW-1:0]) &&
			!sum[DW]) begin
			dmem[ix(i_q, j_q)] <= sum[DW-1:0];
			vmem[ix(i_q, j_q)] <= 1'b1;
			hmem[ix(i_q, j_q)] <= hik_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			for (int r = 0; r < MAX_VERTICES; r++) pres_q[r] <= '0;
			out_valid <= 1'b0;
			{i_q, j_q, k_q, a_q, b_q, n1_q} <= '0;
			last_q <= 1'b0;
		end else begin
			case (st_q)
				S_IDLE: if (q_valid) begin
					a_q  <= q_item.src_vertex[VB-1:0];
					b_q  <= q_item.dst_vertex[VB-1:0];
					w_q  <= WEIGHT_BITS'(q_item.edge_weight);
					n1_q <= VB'(nclip - 4'd1);
					i_q  <= '0;
					j_q  <= '0;
					k_q  <= '0;
					if (q_item.func == FUNC_SOLVE) st_q <= S_INIT;
					else if ({1'b0, q_item.src_vertex} < nclip &&
						{1'b0, q_item.dst_vertex} < nclip) st_q <= S_EDGE_A;
				end
				S_EDGE_A: begin
					pres_q[a_q][b_q] <= 1'b1;
					st_q <= S_EDGE_B;
				end
				S_EDGE_B: begin
					pres_q[b_q][a_q] <= 1'b1;
					st_q <= S_IDLE;
				end
				// Read address was i,j last cycle; pre_q and wrd_q match only after the
				// first step, so each cell is held until last_q is set.
				S_INIT: begin
					if (!last_q) last_q <= 1'b1;
					else begin
						last_q <= 1'b0;
						if (j_q == n1_q) begin
							j_q <= '0;
							if (i_q == n1_q) begin
								i_q <= '0;
								st_q <= S_RIK;
							end else i_q <= i_q + 1'b1;
						end else j_q <= j_q + 1'b1;
					end
				end
				S_RIK: st_q <= S_RKJ;
				S_RKJ: begin
					dik_q <= drd_q;
					vik_q <= vrd_q;
					hik_q <= hrd_q;
					st_q <= S_RIJ;
				end
				S_RIJ: begin
					dkj_q <= drd_q;
					vkj_q <= vrd_q;
					st_q <= S_UPD;
				end
				S_UPD: begin
					if (j_q != n1_q) begin
						j_q <= j_q + 1'b1;
						st_q <= S_RIK;
					end else if (i_q != n1_q) begin
						j_q <= '0;
						i_q <= i_q + 1'b1;
						st_q <= S_RIK;
					end else begin
						j_q <= '0;
						i_q <= '0;
						if (k_q == n1_q) st_q <= S_ERD;
						else begin
							k_q <= k_q + 1'b1;
							st_q <= S_RIK;
						end
					end
				end
				S_ERD: begin
					if (n1_q == '0) st_q <= S_IDLE;
					else if (i_q == j_q) j_q <= j_q + 1'b1;
					else st_q <= S_EWAIT;
				end
				S_EWAIT: begin
					out_item.from_vertex <= 3'(i_q);
					out_item.to_vertex   <= 3'(j_q);
					out_item.reachable   <= vrd_q;
					out_item.path_length <= !vrd_q ? 19'd0 :
						(drd_q > DW'(LEN_MAX)) ? LEN_MAX : 19'(drd_q);
					out_item.next_hop    <= vrd_q ? 3'(hrd_q) : 3'd0;
					out_item.last        <= (i_q == n1_q) &&
						((j_q == n1_q) || (j_q == n1_q - 1'b1 && i_q == n1_q));
					out_valid <= 1'b1;
					st_q <= S_EOUT;
				end
				S_EOUT: if (out_ready) begin
					out_valid <= 1'b0;
					if (out_item.last) begin
						st_q <= S_IDLE;
						i_q <= '0;
						j_q <= '0;
					end else begin
						st_q <= S_ERD;
						if (j_q == n1_q) begin
							j_q <= '0;
							i_q <= i_q + 1'b1;
						end else j_q <= j_q + 1'b1;
					end
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> st_q == S_EOUT) else $error("result shown outside emit");
	a_take_idle: assert property (@(posedge clk) disable iff (!arst_n)
		q_ready |-> !out_valid) else $error("item taken while result pending");
	a_edge_pair: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == S_EDGE_A |=> st_q == S_EDGE_B) else $error("edge store split");
endmodule
`default_nettype wire

// ----- src/all_pairs_shortest_path.sv -----
// Top level of the all-pairs shortest path block.
// Edges load through a two-entry input queue. A solve initialises the distance
// matrix, relaxes it (three reads of a single-port distance memory and one
// write per step), then emits N*(N-1) results; output stalls hold the emitter.
// The vertex count register takes a write only while the queue is empty and the
// solver idle.
`timescale 1ns / 1ps
`default_nettype none
module all_pairs_shortest_path import apsp_pkg::*; #(
	parameter int WEIGHT_BITS  = 16
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_valid,
	output logic            cfg_ready,
	input  wire logic [3:0] cfg_data,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire apsp_in_t   in_item,
	output logic            out_valid,
	input  wire logic       out_ready,
	output apsp_out_t       out_item
);
	logic       q_valid, q_ready, busy;
	apsp_in_t   q_item;
	logic [3:0] vcount_q;

	assign cfg_ready = !busy && !q_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vcount_q <= VC_RESET;
		else if (cfg_valid && cfg_ready) vcount_q <= cfg_data;
	end

	apsp_front u_front (
		.clk, .arst_n, .in_valid, .in_ready, .in_item,
		.q_valid, .q_ready, .q_item
	);

	apsp_back #(.WEIGHT_BITS(WEIGHT_BITS)) u_back (
		.clk, .arst_n, .vcount(vcount_q), .q_valid, .q_ready, .q_item,
		.out_valid, .out_ready, .out_item, .busy
	);
endmodule
`default_nettype wire

// ----- tb/sv/tb.sv -----
// Self-checking testbench for the all-pairs shortest path block.
`timescale 1ns / 1ps
`default_nettype none
module tb;
	import apsp_pkg::*;

	localparam int NV = 8;
	localparam int STALL_LIMIT = 200000;

	logic clk;
	logic arst_n;
	logic cfg_valid;
	logic cfg_ready;
	logic [3:0] cfg_data;
	logic in_valid;
	logic in_ready;
	apsp_in_t in_item;
	logic out_valid;
	logic out_ready;
	apsp_out_t out_item;

	all_pairs_shortest_path u_top (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
		.out_valid(out_valid), .out_ready(out_ready), .out_item(out_item)
	);

	// graph model
	logic [3:0] vc_reg;
	bit edge_set [NV*NV];
	logic [15:0] edge_w [NV*NV];
	apsp_out_t pair_q [$];

	int errors = 0;
	int idle_cycles = 0;
	bit hold_off = 0;
	bit rx_free = 0;

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	function automatic int active_n();
		if (vc_reg == 0) return 1;
		if (vc_reg > NV) return NV;
		return int'(vc_reg);
	endfunction

	// Floyd-Warshall over the stored edges; queue expected pair results
	task automatic predict_solve();
		int n;
		logic [31:0] dmat [NV*NV];
		bit fin [NV*NV];
		logic [2:0] nh [NV*NV];
		logic [31:0] sum;
		apsp_out_t r;
		n = active_n();
		for (int i = 0; i < n; i++)
			for (int j = 0; j < n; j++) begin
				nh[i*NV+j] = 3'(j);
				if (i == j) begin
					fin[i*NV+j] = 1; dmat[i*NV+j] = 0;
				end else if (edge_set[i*NV+j]) begin
					fin[i*NV+j] = 1; dmat[i*NV+j] = {16'd0, edge_w[i*NV+j]};
				end else begin
					fin[i*NV+j] = 0; dmat[i*NV+j] = 0;
				end
			end
		for (int k = 0; k < n; k++)
			for (int i = 0; i < n; i++) begin
				if (!fin[i*NV+k]) continue;
				for (int j = 0; j < n; j++) begin
					if (!fin[k*NV+j]) continue;
					sum = dmat[i*NV+k] + dmat[k*NV+j];
					if (!fin[i*NV+j] || dmat[i*NV+j] > sum) begin
						fin[i*NV+j] = 1;
						dmat[i*NV+j] = sum;
						nh[i*NV+j] = nh[i*NV+k];
					end
				end
			end
		for (int i = 0; i < n; i++)
			for (int j = 0; j < n; j++) begin
				if (i == j) continue;
				r.from_vertex = 3'(i);
				r.to_vertex = 3'(j);
				r.reachable = fin[i*NV+j];
				r.path_length = !fin[i*NV+j] ? 19'd0 :
					(dmat[i*NV+j] > LEN_MAX ? LEN_MAX : dmat[i*NV+j][18:0]);
				r.next_hop = fin[i*NV+j] ? nh[i*NV+j] : 3'd0;
				r.last = (i == n-1) && (j == n-2);
				pair_q.insert(pair_q.size(), r);
			end
	endtask

	task automatic predict_item(input apsp_in_t it);
		int n;
		n = active_n();
		if (it.func == FUNC_SOLVE) begin
			predict_solve();
		end else if (it.src_vertex < n && it.dst_vertex < n) begin
			if (!edge_set[it.src_vertex*NV+it.dst_vertex]) begin
				edge_set[it.src_vertex*NV+it.dst_vertex] = 1;
				edge_w[it.src_vertex*NV+it.dst_vertex] = it.edge_weight;
			end
			if (!edge_set[it.dst_vertex*NV+it.src_vertex]) begin
				edge_set[it.dst_vertex*NV+it.src_vertex] = 1;
				edge_w[it.dst_vertex*NV+it.src_vertex] = it.edge_weight;
			end
		end
	endtask

	// ready only moves at a rising edge, so read it before the edge it governs
	task automatic send_item(input apsp_in_t it);
		bit took;
		in_item = it;
		in_valid = 1;
		forever begin
			took = in_ready;
			@(posedge clk);
			if (took) break;
			@(negedge clk);
		end
		predict_item(it);
		@(negedge clk);
		in_valid = 0;
	endtask

	task automatic send_edge(input int a, input int b, input int w);
		apsp_in_t it;
		it.func = FUNC_EDGE;
		it.src_vertex = 3'(a);
		it.dst_vertex = 3'(b);
		it.edge_weight = 16'(w);
		send_item(it);
	endtask

	task automatic send_solve();
		apsp_in_t it;
		it = '0;
		it.func = FUNC_SOLVE;
		it.src_vertex = 3'($urandom);
		it.dst_vertex = 3'($urandom);
		it.edge_weight = 16'($urandom);
		send_item(it);
	endtask

	task automatic drain();
		while (pair_q.size() != 0) @(negedge clk);
		// edge items give no result; let the block finish them
		repeat (20) @(negedge clk);
	endtask

	task automatic write_count(input logic [3:0] v);
		bit took;
		drain();
		cfg_data = v;
		cfg_valid = 1;
		forever begin
			took = cfg_ready;
			@(posedge clk);
			if (took) break;
			@(negedge clk);
		end
		vc_reg = v;
		@(negedge clk);
		cfg_valid = 0;
	endtask

	task automatic random_gap();
		if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 6)) @(negedge clk);
	endtask

	task automatic test_directed();
		send_solve();                      // empty graph, every pair unreachable
		send_edge(0, 1, 16'hFFFF);
		send_edge(1, 2, 16'hFFFF);
		send_edge(2, 3, 16'hFFFF);
		send_edge(3, 4, 16'hFFFF);
		send_edge(4, 5, 16'hFFFF);
		send_edge(5, 6, 16'hFFFF);
		send_edge(6, 7, 16'hFFFF);         // long chain of heavy edges
		send_edge(1, 0, 1);                // repeated edge keeps first weight
		send_edge(3, 3, 0);                // self-loop
		send_edge(0, 7, 0);
		send_solve();
		write_count(4'd3);
		send_edge(2, 5, 7);                // out of range, dropped
		send_edge(7, 0, 3);
		send_solve();
		write_count(4'd1);
		send_solve();                      // single vertex emits nothing
		write_count(4'd0);
		send_solve();
		write_count(4'd15);
		send_solve();
		write_count(4'd2);
		send_solve();
		drain();
	endtask

	task automatic test_random();
		int sent;
		int burst;
		sent = 0;
		while (sent < 450) begin
			if ($urandom_range(0, 5) == 0)
				write_count(4'($urandom_range(0, 3) == 0 ? $urandom_range(0, 15)
					: $urandom_range(2, 5)));
			burst = $urandom_range(1, 12);
			for (int b = 0; b < burst; b++) begin
				if ($urandom_range(0, 9) == 0)
					send_solve();
				else
					send_edge($urandom_range(0, 7), $urandom_range(0, 7),
						$urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 40));
				sent++;
			end
			random_gap();
		end
	endtask

	task automatic test_backpressure();
		write_count(4'd8);
		hold_off = 1;
		fork
			begin
				repeat (3000) @(negedge clk);
				hold_off = 0;
			end
			begin
				send_solve();
				for (int e = 0; e < 6; e++) send_edge(e, e + 1, $urandom_range(1, 9));
				send_solve();
			end
		join
		drain();
	endtask

	// receiver stall pattern
	always @(negedge clk) begin
		if (hold_off)
			out_ready <= 0;
		else if (rx_free)
			out_ready <= 1;
		else
			out_ready <= ($urandom_range(0, 2) != 0);
	end

	always @(negedge clk) rx_free <= ($urandom_range(0, 63) < 8) ? ~rx_free : rx_free;

	// compare each accepted beat against the oldest expected pair
	always @(posedge clk) begin
		apsp_out_t exp_r;
		if (arst_n && out_valid && out_ready) begin
			if (pair_q.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected beat %p", out_item);
			end else begin
				exp_r = pair_q[0];
				pair_q.delete(0);
				if (out_item !== exp_r) begin
					errors++;
					if (errors <= 10) $display("mismatch exp %p got %p", exp_r, out_item);
				end
			end
		end
	end

	// watchdog on cycles with no accepted beat
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	initial begin
		arst_n = 0;
		cfg_valid = 0;
		cfg_data = '0;
		in_valid = 0;
		in_item = '0;
		out_ready = 0;
		vc_reg = VC_RESET;
		for (int c = 0; c < NV*NV; c++) begin
			edge_set[c] = 0;
			edge_w[c] = 0;
		end
		repeat (3) @(negedge clk);
		arst_n = 1;
		@(negedge clk);
		test_directed();
		test_random();
		test_backpressure();
		drain();
		repeat (50) @(negedge clk);
		if (errors == 0 && pair_q.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end
endmodule
`default_nettype wire
